FILE: sv/mffs_pkg.sv
// ----------------------------------------------------------------------------
// mffs_pkg: shared types and constants for the management frame filter
// Item layouts, configuration register indexes, verdict codes and fixed limits.
// ----------------------------------------------------------------------------
package mffs_pkg;

	localparam int IN_DATA_W   = 184;
	localparam int OUT_DATA_W  = 240;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 48;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_SIGNAL     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUBTYPE_MASK   = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_FILTER_ON = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ADDRESS = 8'd3;

	localparam logic signed [7:0] SIGNAL_FLOOR   = -8'sd127;
	localparam logic signed [7:0] PEAK_RESET     = -8'sd127;
	localparam logic [15:0]       MASK_ALL       = 16'hFFFF;
	localparam logic [1:0]        MGMT_KIND      = 2'd0;
	localparam logic [11:0]       MIN_FRAME_LEN  = 12'd2;
	localparam logic [11:0]       ADDR_FRAME_LEN = 12'd24;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_REJECT = 2'd1,
		VERDICT_IGNORE = 2'd2
	} verdict_t;

	typedef struct packed {
		logic signed [7:0] min_signal;
		logic [15:0]       subtype_enable_mask;
		logic              address_filter_on;
		logic [47:0]       filter_address;
	} cfg_t;

	typedef struct packed {
		logic [15:0]       fc_word;
		logic [47:0]       address_one;
		logic [47:0]       address_two;
		logic [47:0]       address_three;
		logic signed [7:0] signal_dbm;
		logic [3:0]        radio_channel;
		logic [11:0]       frame_length;
	} item_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [31:0]        sequence_res;
		logic [1:0]         frame_kind;
		logic [3:0]         frame_subkind;
		logic [31:0]        subkind_tally;
		logic [31:0]        channel_tally;
		logic [31:0]        rejected_tally;
		logic [63:0]        byte_tally;
		logic signed [31:0] signal_sum;
		logic signed [7:0]  signal_peak;
	} result_t;

endpackage

FILE: sv/mffs_cfg.sv
// ----------------------------------------------------------------------------
// mffs_cfg: configuration registers
// Holds threshold, subtype mask and address filter settings.
// ----------------------------------------------------------------------------
module mffs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mffs_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [mffs_pkg::CFG_DATA_W-1:0]     wr_data,
	output mffs_pkg::cfg_t                      cfg
);

	mffs_pkg::cfg_t cfg_q;
	logic signed [7:0] sig_wr;

	// -128 is stored as the floor value; a zero mask means all enabled
	assign sig_wr = wr_data[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_signal          <= mffs_pkg::SIGNAL_FLOOR;
			cfg_q.subtype_enable_mask <= mffs_pkg::MASK_ALL;
			cfg_q.address_filter_on   <= 1'b0;
			cfg_q.filter_address      <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mffs_pkg::CFG_MIN_SIGNAL: begin
					cfg_q.min_signal <= (sig_wr < mffs_pkg::SIGNAL_FLOOR) ?
						mffs_pkg::SIGNAL_FLOOR : sig_wr;
				end
				mffs_pkg::CFG_SUBTYPE_MASK: begin
					cfg_q.subtype_enable_mask <= (wr_data[15:0] == 16'd0) ?
						mffs_pkg::MASK_ALL : wr_data[15:0];
				end
				mffs_pkg::CFG_ADDR_FILTER_ON: begin
					cfg_q.address_filter_on <= wr_data[0];
				end
				mffs_pkg::CFG_FILTER_ADDRESS: begin
					cfg_q.filter_address <= wr_data[47:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/mffs_filter.sv
// ----------------------------------------------------------------------------
// mffs_filter: frame classification
// Decides accept, reject or ignore for one frame header.
// ----------------------------------------------------------------------------
module mffs_filter (
	input  mffs_pkg::item_t    item,
	input  mffs_pkg::cfg_t     cfg,
	output mffs_pkg::verdict_t verdict
);

	logic [1:0] kind;
	logic [3:0] sub;
	logic       addr_hit;

	assign kind = item.fc_word[3:2];
	assign sub  = item.fc_word[7:4];
	assign addr_hit = (item.address_one   == cfg.filter_address) ||
	                  (item.address_two   == cfg.filter_address) ||
	                  (item.address_three == cfg.filter_address);

	always_comb begin
		priority if (kind != mffs_pkg::MGMT_KIND) begin
			verdict = mffs_pkg::VERDICT_IGNORE;
		end else if ((item.signal_dbm < cfg.min_signal) ||
		             (item.frame_length < mffs_pkg::MIN_FRAME_LEN)) begin
			verdict = mffs_pkg::VERDICT_REJECT;
		end else if (!cfg.subtype_enable_mask[sub]) begin
			verdict = mffs_pkg::VERDICT_REJECT;
		end else if (cfg.address_filter_on &&
		             ((item.frame_length < mffs_pkg::ADDR_FRAME_LEN) || !addr_hit)) begin
			verdict = mffs_pkg::VERDICT_REJECT;
		end else begin
			verdict = mffs_pkg::VERDICT_ACCEPT;
		end
	end

endmodule

FILE: sv/mffs_stats.sv
// ----------------------------------------------------------------------------
// mffs_stats: statistics counters
// Holds all tallies, computes post-update values and commits them on update.
// ----------------------------------------------------------------------------
module mffs_stats #(
	parameter int CHANNEL_COUNT = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  mffs_pkg::item_t    item,
	input  mffs_pkg::verdict_t verdict,
	output mffs_pkg::result_t  res
);

	localparam int CH_IW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [31:0]        accepted_q;
	logic [31:0]        rejected_q;
	logic [31:0]        subk_q [16];
	logic [31:0]        chan_q [CHANNEL_COUNT];
	logic [63:0]        len_total_q;
	logic signed [31:0] sum_q;
	logic signed [7:0]  peak_q;

	logic               acc;
	logic               rej;
	logic [3:0]         sub;
	logic               chan_ok;
	logic [3:0]         chan_m1;
	logic [CH_IW-1:0]   chan_idx;
	logic [31:0]        acc_nx;
	logic [31:0]        rej_nx;
	logic [31:0]        subk_nx;
	logic [31:0]        chan_cur;
	logic [31:0]        chan_nx;
	logic [63:0]        len_nx;
	logic signed [31:0] sum_nx;
	logic signed [7:0]  peak_nx;

	assign acc      = (verdict == mffs_pkg::VERDICT_ACCEPT);
	assign rej      = (verdict == mffs_pkg::VERDICT_REJECT);
	assign sub      = item.fc_word[7:4];
	assign chan_ok  = (item.radio_channel >= 4'd1) &&
	                  (item.radio_channel <= 4'(CHANNEL_COUNT));
	assign chan_m1  = item.radio_channel - 4'd1;
	assign chan_idx = chan_m1[CH_IW-1:0];

	assign acc_nx   = accepted_q + {31'd0, acc};
	assign rej_nx   = rejected_q + {31'd0, rej};
	assign subk_nx  = subk_q[sub] + {31'd0, acc};
	assign chan_cur = chan_ok ? chan_q[chan_idx] : 32'd0;
	assign chan_nx  = chan_cur + {31'd0, acc && chan_ok};
	assign len_nx   = len_total_q + (acc ? {52'd0, item.frame_length} : 64'd0);
	assign sum_nx   = sum_q + (acc ? {{24{item.signal_dbm[7]}}, item.signal_dbm} : 32'sd0);
	assign peak_nx  = (acc && (item.signal_dbm > peak_q)) ? item.signal_dbm : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q  <= '0;
			rejected_q  <= '0;
			len_total_q <= '0;
			sum_q       <= '0;
			peak_q      <= mffs_pkg::PEAK_RESET;
			for (int i = 0; i < 16; i++) begin
				subk_q[i] <= '0;
			end
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				chan_q[i] <= '0;
			end
		end else if (upd) begin
			accepted_q  <= acc_nx;
			rejected_q  <= rej_nx;
			len_total_q <= len_nx;
			sum_q       <= sum_nx;
			peak_q      <= peak_nx;
			if (acc) begin
				subk_q[sub] <= subk_nx;
			end
			if (acc && chan_ok) begin
				chan_q[chan_idx] <= chan_nx;
			end
		end
	end

	always_comb begin
		res.verdict        = verdict;
		res.sequence_res   = acc_nx;
		res.frame_kind     = item.fc_word[3:2];
		res.frame_subkind  = sub;
		res.subkind_tally  = subk_nx;
		res.channel_tally  = chan_nx;
		res.rejected_tally = rej_nx;
		res.byte_tally     = len_nx;
		res.signal_sum     = sum_nx;
		res.signal_peak    = peak_nx;
	end

endmodule

FILE: sv/mgmt_frame_filter_stats.sv
// ----------------------------------------------------------------------------
// mgmt_frame_filter_stats: 802.11 management frame filter and statistics
// Classifies received frame headers and keeps per-subtype, per-channel,
// byte, signal and reject tallies; one result per frame header.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   frame header (184 bits)
// m_*       out        m_tvalid/m_tready   verdict and tallies (240 bits)
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// Throughput is one frame header per cycle while the output is not stalled;
// a header passes the input register and then the output register before
// m_tvalid rises. The input register feeds filter and counter update logic,
// which commit at the same edge that loads the output register, so the next
// frame always sees updated counts.
// Reset clears all counters (peak to -127) and loads register defaults.
// A stalled output holds its result while the input register still takes
// one more header; cfg_ready is always high.
//
module mgmt_frame_filter_stats #(
	parameter int CHANNEL_COUNT = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// fc_word, address_one, address_two, address_three, signal_dbm,
	// radio_channel, frame_length
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mffs_pkg::IN_DATA_W-1:0]    s_tdata,
	// verdict, sequence_res, frame_kind, frame_subkind, subkind_tally,
	// channel_tally, rejected_tally, byte_tally, signal_sum, signal_peak
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mffs_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mffs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mffs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	mffs_pkg::item_t    item_in;
	mffs_pkg::item_t    item_s1;
	logic               vld_s1;
	mffs_pkg::result_t  res_s2;
	logic               vld_s2;
	mffs_pkg::cfg_t     cfg;
	mffs_pkg::verdict_t verdict;
	mffs_pkg::result_t  res_nx;
	logic               s_fire;
	logic               adv;
	logic               upd;

	// unpack the input transaction, first field lowest
	always_comb begin
		item_in.fc_word       = s_tdata[15:0];
		item_in.address_one   = s_tdata[63:16];
		item_in.address_two   = s_tdata[111:64];
		item_in.address_three = s_tdata[159:112];
		item_in.signal_dbm    = s_tdata[167:160];
		item_in.radio_channel = s_tdata[171:168];
		item_in.frame_length  = s_tdata[183:172];
	end

	// output slot frees when empty or being taken this cycle
	assign adv      = !vld_s2 || m_tready;
	assign upd      = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_fire || (vld_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= item_in;
		end
	end

	assign cfg_ready = 1'b1;

	mffs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	mffs_filter u_filter (
		.item    (item_s1),
		.cfg     (cfg),
		.verdict (verdict)
	);

	// counters commit together with the output register load
	mffs_stats #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_stats (
		.clk     (clk),
		.arst_n  (arst_n),
		.upd     (upd),
		.item    (item_s1),
		.verdict (verdict),
		.res     (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= upd || (vld_s2 && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			res_s2 <= res_nx;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {res_s2.signal_peak, res_s2.signal_sum, res_s2.byte_tally,
	                   res_s2.rejected_tally, res_s2.channel_tally, res_s2.subkind_tally,
	                   res_s2.frame_subkind, res_s2.frame_kind, res_s2.sequence_res,
	                   res_s2.verdict};

	// input stalls only while both stages hold data and the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && !m_tready))
		else $error("input stalled with a free stage");

	// a header that advances always shows up as a result next cycle
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> m_tvalid)
		else $error("advanced header produced no result");

	// ignore verdict exactly for non-management frame types
	a_ignore_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_s2.verdict == mffs_pkg::VERDICT_IGNORE) ==
		              (res_s2.frame_kind != mffs_pkg::MGMT_KIND)))
		else $error("verdict does not match frame type");

	// an accepted frame advances the accepted count (checked while the output is taken)
	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && (verdict == mffs_pkg::VERDICT_ACCEPT) && vld_s2 && m_tready) |=>
		(res_s2.sequence_res == $past(res_s2.sequence_res) + 32'd1))
		else $error("accepted count did not advance");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for mgmt_frame_filter_stats
// Streams frame headers through the filter under random handshake gaps and
// a long output stall. A behavioral copy of the filter and its tallies
// predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NUM_CHANNELS    = 13;
	localparam int DRAIN_CYCLES    = 4;     // pipeline is two deep, plus margin
	localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before giving up
	localparam int HOLD_CYCLES     = 300;   // long receiver stall
	localparam int RAND_PHASES     = 8;
	localparam int FRAMES_PER_PHASE = 90;
	localparam int PRESSURE_PHASE  = 3;
	localparam int QUIET_PHASE     = 1;     // no gaps on either side

	// index past the register map; the block must drop writes to it
	localparam logic [mffs_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 8'd200;

	localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;
	localparam logic [47:0] STATION_A  = 48'h02_11_22_33_44_55;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_tvalid  = 1'b0;
	logic                             s_tready;
	logic [mffs_pkg::IN_DATA_W-1:0]   s_tdata;
	logic                             m_tvalid;
	logic                             m_tready  = 1'b0;
	logic [mffs_pkg::OUT_DATA_W-1:0]  m_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [mffs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [mffs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

	// header currently offered on the input side
	mffs_pkg::item_t cur_hdr = '0;

	// s_tdata, lowest bit up: fc_word, address_one, address_two,
	// address_three, signal_dbm, radio_channel, frame_length
	assign s_tdata = {cur_hdr.frame_length, cur_hdr.radio_channel, cur_hdr.signal_dbm,
		cur_hdr.address_three, cur_hdr.address_two, cur_hdr.address_one,
		cur_hdr.fc_word};

	mgmt_frame_filter_stats #(
		.CHANNEL_COUNT(NUM_CHANNELS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the filter: settings as the block stores them, plus tallies
	// ------------------------------------------------------------------
	logic signed [7:0]  thr_signal;
	logic [15:0]        sub_mask;
	logic               addr_match_on;
	logic [47:0]        match_addr;

	logic [31:0]        acc_total;
	logic [31:0]        rej_total;
	logic [31:0]        per_sub [16];
	logic [31:0]        per_chan [1:NUM_CHANNELS];
	logic [63:0]        len_sum;
	logic signed [31:0] sig_total;
	logic signed [7:0]  sig_max;

	mffs_pkg::item_t   hdr_q[$];       // headers waiting for the driver
	mffs_pkg::result_t expected_q[$];  // predicted results, oldest first

	// handshake bookkeeping shared between the edge processes
	bit hdr_taken, res_taken;
	bit src_gaps_on, snk_gaps_on;
	bit hold_req;
	int src_gap, snk_gap, hold_left;

	int mismatches;
	int n_frames, n_accept, n_reject, n_ignore, n_cfg;

	// Filter decision and tally update for one header; returns the result
	// the block should produce for it.
	function automatic mffs_pkg::result_t classify_frame(mffs_pkg::item_t h);
		mffs_pkg::result_t r;
		logic [1:0] kind;
		logic [3:0] sub;
		logic       chan_ok, addr_hit, turned_away;
		kind     = h.fc_word[3:2];
		sub      = h.fc_word[7:4];
		chan_ok  = h.radio_channel >= 1 && h.radio_channel <= NUM_CHANNELS;
		addr_hit = h.address_one == match_addr || h.address_two == match_addr ||
			h.address_three == match_addr;
		if (kind != mffs_pkg::MGMT_KIND) begin
			r.verdict = mffs_pkg::VERDICT_IGNORE;
		end else begin
			// signal and minimum length come first, then subtype, then address
			turned_away = $signed(h.signal_dbm) < $signed(thr_signal) ||
				h.frame_length < mffs_pkg::MIN_FRAME_LEN || !sub_mask[sub] ||
				(addr_match_on &&
				(h.frame_length < mffs_pkg::ADDR_FRAME_LEN || !addr_hit));
			if (turned_away) begin
				r.verdict = mffs_pkg::VERDICT_REJECT;
				rej_total = rej_total + 1;
			end else begin
				r.verdict    = mffs_pkg::VERDICT_ACCEPT;
				acc_total    = acc_total + 1;
				per_sub[sub] = per_sub[sub] + 1;
				if (chan_ok)
					per_chan[h.radio_channel] = per_chan[h.radio_channel] + 1;
				len_sum   = len_sum + h.frame_length;
				sig_total = sig_total + $signed(h.signal_dbm);
				if ($signed(h.signal_dbm) > sig_max)
					sig_max = h.signal_dbm;
			end
		end
		r.sequence_res   = acc_total;
		r.frame_kind     = kind;
		r.frame_subkind  = sub;
		r.subkind_tally  = per_sub[sub];
		r.channel_tally  = chan_ok ? per_chan[h.radio_channel] : '0;
		r.rejected_tally = rej_total;
		r.byte_tally     = len_sum;
		r.signal_sum     = sig_total;
		r.signal_peak    = sig_max;
		return r;
	endfunction

	function automatic logic [47:0] rnd48();
		return 48'({$urandom, $urandom});
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap(bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic mffs_pkg::item_t mk_frame(logic [1:0] kind, logic [3:0] sub,
		int sig, logic [3:0] chan, int len, logic [47:0] a1, logic [47:0] a2,
		logic [47:0] a3);
		mffs_pkg::item_t h;
		h.fc_word            = 16'($urandom);
		h.fc_word[3:2]       = kind;
		h.fc_word[7:4]       = sub;
		h.address_one        = a1;
		h.address_two        = a2;
		h.address_three      = a3;
		h.signal_dbm         = 8'(sig);
		h.radio_channel      = chan;
		h.frame_length       = 12'(len);
		return h;
	endfunction

	// Mostly management frames that can pass the current settings, with
	// the rest spread over other types, weak signals and short frames.
	function automatic mffs_pkg::item_t random_frame();
		mffs_pkg::item_t h;
		int    lo, pick;
		lo = thr_signal;
		h.fc_word = 16'($urandom);
		if ($urandom_range(0, 3) != 0)
			h.fc_word[3:2] = mffs_pkg::MGMT_KIND;
		else
			h.fc_word[3:2] = 2'($urandom_range(1, 3));
		h.address_one   = rnd48();
		h.address_two   = rnd48();
		h.address_three = rnd48();
		pick = $urandom_range(0, 9);
		if (pick < 2)
			h.address_one = match_addr;
		else if (pick < 3)
			h.address_two = match_addr;
		else if (pick < 4)
			h.address_three = match_addr;
		if ($urandom_range(0, 9) < 8)
			h.signal_dbm = 8'(lo + $urandom_range(0, 127 - lo));
		else
			h.signal_dbm = 8'($urandom);
		h.radio_channel = 4'($urandom);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			h.frame_length = 12'($urandom_range(0, 1));
		else if (pick < 4)
			h.frame_length = 12'($urandom_range(2, 23));
		else
			h.frame_length = 12'($urandom_range(24, 4095));
		return h;
	endfunction

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Register write; back-to-back writes keep cfg_valid high, the caller
	// drops it after the last one.
	task automatic write_reg(logic [mffs_pkg::CFG_INDEX_W-1:0] idx,
		logic [mffs_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Wait until every header went in and every result came out.
	task automatic settle();
		do @(posedge clk);
		while (hdr_q.size() != 0 || s_tvalid || expected_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Input driver: offers queued headers at the falling edge; a header
	// stays on the bus until its transaction completes.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || hdr_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (hdr_q.size() != 0) begin
				cur_hdr  <= hdr_q.pop_front();
				s_tvalid <= 1'b1;
				src_gap = pick_gap(src_gaps_on);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		hdr_taken = 1'b0;
	end

	// ------------------------------------------------------------------
	// Output side ready: random stalls after each transaction, plus the
	// long hold requested by the stimulus to back up the pipeline.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (res_taken)
			snk_gap = pick_gap(snk_gaps_on);
		res_taken = 1'b0;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: tracks register writes, predicts each accepted header and
	// checks each result against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		mffs_pkg::result_t want, got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				n_cfg++;
				case (cfg_index)
					mffs_pkg::CFG_MIN_SIGNAL: begin
						// -128 is clamped to the floor
						if (cfg_data[7:0] == 8'h80)
							thr_signal = mffs_pkg::SIGNAL_FLOOR;
						else
							thr_signal = cfg_data[7:0];
					end
					mffs_pkg::CFG_SUBTYPE_MASK: begin
						// an all-clear mask means all subtypes on
						sub_mask = (cfg_data[15:0] == '0) ? mffs_pkg::MASK_ALL :
							cfg_data[15:0];
					end
					mffs_pkg::CFG_ADDR_FILTER_ON: addr_match_on = cfg_data[0];
					mffs_pkg::CFG_FILTER_ADDRESS: match_addr    = cfg_data[47:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(classify_frame(cur_hdr));
				hdr_taken = 1'b1;
				n_frames++;
			end
			if (m_tvalid && m_tready) begin
				res_taken = 1'b1;
				got.verdict        = mffs_pkg::verdict_t'(m_tdata[1:0]);
				got.sequence_res   = m_tdata[33:2];
				got.frame_kind     = m_tdata[35:34];
				got.frame_subkind  = m_tdata[39:36];
				got.subkind_tally  = m_tdata[71:40];
				got.channel_tally  = m_tdata[103:72];
				got.rejected_tally = m_tdata[135:104];
				got.byte_tally     = m_tdata[199:136];
				got.signal_sum     = m_tdata[231:200];
				got.signal_peak    = m_tdata[239:232];
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					check_field("verdict", 64'(want.verdict), 64'(got.verdict));
					check_field("sequence_res", 64'(want.sequence_res),
						64'(got.sequence_res));
					check_field("frame_kind", 64'(want.frame_kind),
						64'(got.frame_kind));
					check_field("frame_subkind", 64'(want.frame_subkind),
						64'(got.frame_subkind));
					check_field("subkind_tally", 64'(want.subkind_tally),
						64'(got.subkind_tally));
					check_field("channel_tally", 64'(want.channel_tally),
						64'(got.channel_tally));
					check_field("rejected_tally", 64'(want.rejected_tally),
						64'(got.rejected_tally));
					check_field("byte_tally", want.byte_tally, got.byte_tally);
					check_field("signal_sum", 64'(want.signal_sum),
						64'(got.signal_sum));
					check_field("signal_peak", 64'(want.signal_peak),
						64'(got.signal_peak));
				end
				case (got.verdict)
					mffs_pkg::VERDICT_ACCEPT: n_accept++;
					mffs_pkg::VERDICT_REJECT: n_reject++;
					default:                  n_ignore++;
				endcase
			end
		end
	end

	// Watchdog: too long without any transaction on any channel.
	int quiet_cycles;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: stuck, %0d results outstanding, %0d headers queued",
					$time, expected_q.size(), hdr_q.size());
				$display("[mgmt_frame_filter_stats] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int                p, i;
		logic [7:0]        thr8;
		logic [15:0]       mask16;
		logic [47:0]       addr48;
		logic              on1;

		// shadow state as after reset
		thr_signal    = mffs_pkg::SIGNAL_FLOOR;
		sub_mask      = mffs_pkg::MASK_ALL;
		addr_match_on = 1'b0;
		match_addr    = '0;
		acc_total     = '0;
		rej_total     = '0;
		foreach (per_sub[k])
			per_sub[k] = '0;
		foreach (per_chan[k])
			per_chan[k] = '0;
		len_sum     = '0;
		sig_total   = '0;
		sig_max     = mffs_pkg::PEAK_RESET;
		src_gaps_on = 1'b1;
		snk_gaps_on = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: type filter, signal floor, short frames, channels
		hdr_q.push_back(mk_frame(2'd1, 4'd8, 0, 4'd6, 100, rnd48(), rnd48(), rnd48()));
		hdr_q.push_back(mk_frame(2'd2, 4'd0, 0, 4'd6, 100, rnd48(), rnd48(), rnd48()));
		hdr_q.push_back(mk_frame(2'd3, 4'd15, 0, 4'd6, 100, rnd48(), rnd48(), rnd48()));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd0, -128, 4'd1, 100,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd0, -127, 4'd1, 2,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd15, 127, 4'd13, 4095,
			BCAST_ADDR, BCAST_ADDR, BCAST_ADDR));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd4, 10, 4'd2, 0, '0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd4, 10, 4'd2, 1, '0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd4, -40, 4'd0, 60,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd8, -60, 4'd14, 60,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd8, -20, 4'd15, 60,
			'0, '0, '0));
		settle();

		// clamped threshold, cleared mask, address filter on, stray index
		write_reg(mffs_pkg::CFG_MIN_SIGNAL, 48'h80);
		write_reg(mffs_pkg::CFG_SUBTYPE_MASK, 48'h0);
		write_reg(mffs_pkg::CFG_FILTER_ADDRESS, STATION_A);
		write_reg(mffs_pkg::CFG_ADDR_FILTER_ON, 48'h1);
		write_reg(CFG_UNUSED_IDX, BCAST_ADDR);
		@(negedge clk);
		cfg_valid <= 1'b0;
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd5, 0, 4'd6, 23,
			STATION_A, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd5, 0, 4'd6, 24,
			STATION_A, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd5, 0, 4'd6, 24,
			'0, STATION_A, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd5, 0, 4'd6, 24,
			'0, '0, STATION_A));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd5, 0, 4'd6, 24,
			'0, BCAST_ADDR, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd9, -128, 4'd7, 64,
			STATION_A, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd9, -127, 4'd7, 64,
			STATION_A, '0, '0));
		settle();

		// top threshold and a sparse subtype mask
		write_reg(mffs_pkg::CFG_MIN_SIGNAL, 48'h7F);
		write_reg(mffs_pkg::CFG_SUBTYPE_MASK, 48'h8001);
		write_reg(mffs_pkg::CFG_ADDR_FILTER_ON, 48'h0);
		write_reg(mffs_pkg::CFG_FILTER_ADDRESS, 48'h0);
		@(negedge clk);
		cfg_valid <= 1'b0;
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd0, 127, 4'd3, 30,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd15, 127, 4'd3, 30,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd1, 127, 4'd3, 30,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(mffs_pkg::MGMT_KIND, 4'd0, 126, 4'd3, 30,
			'0, '0, '0));
		hdr_q.push_back(mk_frame(2'd3, 4'd1, 127, 4'd3, 30, '0, '0, '0));

		// random phases, each under its own settings
		for (p = 0; p < RAND_PHASES; p++) begin
			settle();
			if (p == 0) begin
				thr8   = 8'h81;
				mask16 = mffs_pkg::MASK_ALL;
				on1    = 1'b0;
				addr48 = rnd48();
			end else if (p == RAND_PHASES - 1) begin
				thr8   = 8'h7F;
				mask16 = mffs_pkg::MASK_ALL;
				on1    = 1'b1;
				addr48 = BCAST_ADDR;
			end else begin
				case ($urandom_range(0, 4))
					0:       thr8 = 8'h80;
					1:       thr8 = 8'h81;
					default: thr8 = 8'($urandom_range(0, 100) - 100);
				endcase
				case ($urandom_range(0, 3))
					0:       mask16 = '0;
					1:       mask16 = mffs_pkg::MASK_ALL;
					2:       mask16 = 16'(1) << $urandom_range(0, 15);
					default: mask16 = 16'($urandom);
				endcase
				on1    = 1'($urandom_range(0, 1));
				addr48 = ($urandom_range(0, 3) == 0) ? 48'h0 : rnd48();
			end
			// upper data bits are don't-care for the narrow registers
			write_reg(mffs_pkg::CFG_MIN_SIGNAL, 48'({rnd48(), thr8}));
			write_reg(mffs_pkg::CFG_SUBTYPE_MASK, 48'({rnd48(), mask16}));
			write_reg(mffs_pkg::CFG_ADDR_FILTER_ON, 48'({rnd48(), on1}));
			write_reg(mffs_pkg::CFG_FILTER_ADDRESS, addr48);
			if (p % 2 == 1)
				write_reg(CFG_UNUSED_IDX, rnd48());
			@(negedge clk);
			cfg_valid <= 1'b0;
			@(posedge clk);

			src_gaps_on = (p != QUIET_PHASE);
			snk_gaps_on = (p != QUIET_PHASE);
			if (p == PRESSURE_PHASE) begin
				// sender keeps pushing while the receiver sits on its hands
				src_gaps_on = 1'b0;
				hold_req    = 1'b1;
			end
			for (i = 0; i < FRAMES_PER_PHASE; i++)
				hdr_q.push_back(random_frame());
		end
		settle();

		$display("frames %0d: accepted %0d, rejected %0d, ignored %0d", n_frames,
			n_accept, n_reject, n_ignore);
		$display("register writes %0d over %0d settings, one long output stall",
			n_cfg, RAND_PHASES + 3);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[mgmt_frame_filter_stats] OK");
		else
			$display("[mgmt_frame_filter_stats] ERROR");
		$finish;
	end

endmodule
